@@ design/crc8p_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// CRC-8 packet parser package
// Types, constants and the CRC step shared by the parser files.
// ---------------------------------------------------------------------------
package crc8p_pkg;

  localparam int unsigned DEF_MAX_PAYLOAD = 32;
  localparam logic [7:0]  CRC_POLY        = 8'h07;
  localparam logic [7:0]  CRC_TOP         = 8'h80;
  localparam logic [7:0]  CRC_INIT        = 8'h00;
  localparam logic [7:0]  START_RESET     = 8'hAA;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_CMD,
    ST_LEN,
    ST_DATA,
    ST_CHECK,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] start_byte;
  } cfg_word_t;

  typedef struct packed {
    logic [7:0] command;
    logic [5:0] payload_len;
    logic [4:0] payload_index;
    logic [7:0] payload_byte;
    logic       payload_present;
    logic       last;
  } out_word_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/crc8p_stream_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Valid/ready stream channel
// Carries one word of type T per handshake.
// ---------------------------------------------------------------------------
interface crc8p_stream_if
  import crc8p_pkg::*;
#(
  parameter type T = in_word_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/crc8p_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module crc8p_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/crc8_framed_packet_parser.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// CRC-8 length-framed packet parser
// Hunts for the start byte, takes command, length, payload and CRC, and
// emits each good frame as a run of payload words.
// ---------------------------------------------------------------------------
// While a frame is being received the parser takes one input word every
// cycle that one is offered. Payload bytes are written into a payload RAM
// as they arrive. When the CRC word matches, the parser stops taking input
// and plays the frame out of the RAM, each result word by a RAM read step
// and then an output register load, so the input stays closed until the
// last word is loaded, and longer on any stall on the output side. A
// finished result waits in the output register while hunting resumes. A
// failed CRC or an oversized length returns to hunting with no output.
// ---------------------------------------------------------------------------
module crc8_framed_packet_parser
  import crc8p_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input wire logic       clk,
  input wire logic       rst_n,
  crc8p_stream_if.sink   in_ch,
  crc8p_stream_if.sink   cfg_ch,
  crc8p_stream_if.source out_ch
);

  localparam int unsigned LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  state_t           state_r, state_nxt;
  logic [7:0]       start_r;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  logic             in_take;
  logic [7:0]       b;
  logic             ram_we, ram_re;
  logic [7:0]       ram_rdata;
  logic [LEN_W-1:0] cnt_inc;
  logic             emit_last;

  assign in_ch.ready  = (state_r != ST_EMIT_RD) && (state_r != ST_EMIT_WR);
  assign in_take      = in_ch.valid && in_ch.ready;
  assign b            = in_ch.data.rx_byte;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign cnt_inc   = LEN_W'(cnt_r + 1'b1);
  assign emit_last = (len_r == '0) || (cnt_inc == len_r);
  assign ram_we    = in_take && (state_r == ST_DATA);
  assign ram_re    = (state_r == ST_EMIT_RD);

  crc8p_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD),
    .ADDR_W(ADDR_W)
  ) u_payload_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata(b),
    .re   (ram_re),
    .raddr(cnt_r[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_HUNT: begin
        if (in_take && (b == start_r)) begin
          state_nxt = ST_CMD;
        end
      end
      ST_CMD: begin
        if (in_take) begin
          cmd_nxt   = b;
          crc_nxt   = crc_feed(CRC_INIT, b);
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_take) begin
          if (b > 8'(MAX_PAYLOAD)) begin
            state_nxt = ST_HUNT;
          end else begin
            len_nxt   = LEN_W'(b);
            crc_nxt   = crc_feed(crc_r, b);
            cnt_nxt   = '0;
            state_nxt = (b == 8'h00) ? ST_CHECK : ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (in_take) begin
          crc_nxt = crc_feed(crc_r, b);
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (in_take) begin
          cnt_nxt   = '0;
          state_nxt = (b == crc_r) ? ST_EMIT_RD : ST_HUNT;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.command         = cmd_r;
          out_data_nxt.payload_len     = 6'(len_r);
          out_data_nxt.payload_index   = 5'(cnt_r);
          out_data_nxt.payload_present = (len_r != '0);
          out_data_nxt.payload_byte    = (len_r != '0) ? ram_rdata : 8'h00;
          out_data_nxt.last            = emit_last;
          cnt_nxt                      = cnt_inc;
          state_nxt                    = emit_last ? ST_HUNT : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      start_r     <= START_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      len_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      if (cfg_ch.valid) begin
        start_r <= cfg_ch.data.start_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    crc_r      <= crc_nxt;
    out_data_r <= out_data_nxt;
  end

  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT_WR))
    else $error("Output became valid outside the play-out phase.");

  a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !(state_r == ST_EMIT_RD || state_r == ST_EMIT_WR))
    else $error("Payload RAM written while the frame is being played out.");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DATA |-> cnt_r < len_r)
    else $error("Payload count reached the frame length while still in data.");

  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_RD |-> (cnt_r < len_r) || (len_r == '0 && cnt_r == '0))
    else $error("Play-out index ran beyond the frame length.");

  a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_RD |=> state_r == ST_EMIT_WR)
    else $error("RAM read was not followed by the output load step.");

endmodule
`default_nettype wire

@@ test/crc8_framed_packet_parser_tb.sv @@
// ---------------------------------------------------------------------------
// Testbench for the CRC-8 length-framed packet parser
// Drives received bytes as well-formed frames, frames with a bad CRC,
// oversized lengths, cut-off frames and loose noise. The start byte is set
// to several values, including 0x00 and 0xFF. A frame tracker follows the
// parser state byte by byte and predicts every result word. Each word that
// leaves the block is then compared field by field, in order, with the
// prediction. Both sides of the block idle and stall at random.
// ---------------------------------------------------------------------------
module crc8_framed_packet_parser_tb;
  import crc8p_pkg::*;

  localparam int unsigned MAX_PAYLOAD = DEF_MAX_PAYLOAD;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 80;

  class frame_tracker;
    state_t     phase;
    logic [7:0] start_code;
    logic [7:0] cmd;
    logic [5:0] len;
    logic [5:0] got;
    logic [7:0] crc;
    logic [7:0] payload_copy [MAX_PAYLOAD];
    out_word_t  expected_words [$];
    int         mismatches;
    int         words_checked;
    int         good_frames;
    int         parsed_bytes;

    function new();
      phase = ST_HUNT;
      start_code = START_RESET;
      cmd = '0;
      len = '0;
      got = '0;
      crc = CRC_INIT;
      mismatches = 0;
      words_checked = 0;
      good_frames = 0;
      parsed_bytes = 0;
    endfunction

    static function logic [7:0] crc_next(input logic [7:0] c, input logic [7:0] b);
      logic [7:0] r;
      logic       msb;
      r = c ^ b;
      for (int k = 0; k < 8; k++) begin
        msb = r[7];
        r = {r[6:0], 1'b0} ^ (msb ? CRC_POLY : 8'h00);
      end
      return r;
    endfunction

    function void set_start(input logic [7:0] code);
      start_code = code;
    endfunction

    function void take_byte(input logic [7:0] b);
      out_word_t w;
      if (phase != ST_HUNT || b == start_code) begin
        parsed_bytes++;
      end
      case (phase)
        ST_HUNT: begin
          if (b == start_code) begin
            phase = ST_CMD;
            got = '0;
            crc = CRC_INIT;
          end
        end
        ST_CMD: begin
          cmd = b;
          crc = crc_next(CRC_INIT, b);
          phase = ST_LEN;
        end
        ST_LEN: begin
          if (b > MAX_PAYLOAD) begin
            phase = ST_HUNT;
          end else begin
            len = b[5:0];
            crc = crc_next(crc, b);
            got = '0;
            phase = (b == 8'h00) ? ST_CHECK : ST_DATA;
          end
        end
        ST_DATA: begin
          payload_copy[got[4:0]] = b;
          crc = crc_next(crc, b);
          got++;
          if (got >= len) begin
            phase = ST_CHECK;
          end
        end
        ST_CHECK: begin
          phase = ST_HUNT;
          if (b == crc) begin
            good_frames++;
            w.command = cmd;
            w.payload_len = len;
            if (len == 0) begin
              w.payload_index = '0;
              w.payload_byte = '0;
              w.payload_present = 1'b0;
              w.last = 1'b1;
              expected_words.push_back(w);
            end else begin
              for (int i = 0; i < len; i++) begin
                w.payload_index = 5'(i);
                w.payload_byte = payload_copy[i];
                w.payload_present = 1'b1;
                w.last = (i == len - 1);
                expected_words.push_back(w);
              end
            end
          end
        end
        default: begin
          phase = ST_HUNT;
        end
      endcase
    endfunction

    function void match_field(input string name, input logic [7:0] want,
                              input logic [7:0] seen);
      if (want !== seen) begin
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_word(input out_word_t w);
      out_word_t e;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got 0x%0h", $time, w);
        mismatches++;
      end else begin
        e = expected_words.pop_front();
        words_checked++;
        match_field("command", e.command, w.command);
        match_field("payload_len", 8'(e.payload_len), 8'(w.payload_len));
        match_field("payload_index", 8'(e.payload_index), 8'(w.payload_index));
        match_field("payload_byte", e.payload_byte, w.payload_byte);
        match_field("payload_present", 8'(e.payload_present), 8'(w.payload_present));
        match_field("last", 8'(e.last), 8'(w.last));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic [7:0] start_code = START_RESET;
  bit steady = 1'b0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  frame_tracker tracker;

  crc8p_stream_if #(.T(in_word_t))  in_ch ();
  crc8p_stream_if #(.T(cfg_word_t)) cfg_ch ();
  crc8p_stream_if #(.T(out_word_t)) out_ch ();

  crc8_framed_packet_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .cfg_ch(cfg_ch),
    .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (steady) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ~out_ch.ready;
      hold_cnt <= out_ch.ready ? pick_gap() : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.check_word(out_ch.data);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timed out after %0d cycles with no word moving.", IDLE_LIMIT);
      $display("crc8_framed_packet_parser_tb: FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.take_byte(b);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] body [$],
                            input bit spoil);
    logic [7:0] c;
    c = frame_tracker::crc_next(CRC_INIT, cmd);
    c = frame_tracker::crc_next(c, 8'(body.size()));
    foreach (body[i]) c = frame_tracker::crc_next(c, body[i]);
    if (spoil) begin
      c = c ^ 8'($urandom_range(1, 255));
    end
    send_byte(start_code);
    send_byte(cmd);
    send_byte(8'(body.size()));
    foreach (body[i]) send_byte(body[i]);
    send_byte(c);
  endtask

  task automatic random_frame(input bit spoil);
    logic [7:0] body [$];
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      n = MAX_PAYLOAD;
    end else if (r < 18) begin
      n = $urandom_range(20, MAX_PAYLOAD - 1);
    end else begin
      n = $urandom_range(0, 6);
    end
    repeat (n) body.push_back(8'($urandom));
    send_frame(8'($urandom), body, spoil);
  endtask

  task automatic random_phase(input int budget);
    int stop_at;
    int r;
    int n;
    stop_at = tracker.parsed_bytes + budget;
    while (tracker.parsed_bytes < stop_at) begin
      steady = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        random_frame(1'b0);
      end else if (r < 80) begin
        random_frame(1'b1);
      end else if (r < 88) begin
        send_byte(start_code);
        send_byte(8'($urandom));
        send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      end else if (r < 94) begin
        n = $urandom_range(2, 8);
        send_byte(start_code);
        send_byte(8'($urandom));
        send_byte(8'(n));
        repeat ($urandom_range(0, n - 1)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (tracker.expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_start(input logic [7:0] code);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data.start_byte <= code;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.set_start(code);
    start_code = code;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] body [$];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    tracker = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Short directed frames at the reset start byte.
    send_byte(8'h00);
    body = {};
    send_frame(8'h00, body, 1'b0);
    body = {START_RESET};
    send_frame(8'hFF, body, 1'b0);
    send_byte(start_code);
    send_byte(8'h12);
    send_byte(8'(MAX_PAYLOAD + 1));
    body = {8'hFF, 8'h00};
    send_frame(8'h5A, body, 1'b1);
    body = {8'h01, 8'h80};
    send_frame(8'h80, body, 1'b0);
    drain_results();

    write_start(8'h00);
    random_phase(80);
    drain_results();

    write_start(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h3C);
    send_byte(8'hFF);
    body = {};
    repeat (MAX_PAYLOAD) body.push_back(8'($urandom));
    send_frame(8'($urandom), body, 1'b0);
    random_phase(80);
    drain_results();

    write_start(8'($urandom));
    random_phase(80);
    drain_results();

    write_start(START_RESET);
    random_phase(80);
    drain_results();

    $display("Parsed %0d frame bytes under four start bytes including 0x00 and 0xFF.",
             tracker.parsed_bytes);
    $display("%0d frames passed the CRC and %0d result words were compared.",
             tracker.good_frames, tracker.words_checked);
    if (tracker.mismatches == 0) begin
      $display("crc8_framed_packet_parser_tb: PASS");
    end else begin
      $display("crc8_framed_packet_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
